@@ design/unsigned_64bit_alu_assert.svh @@
// assertion macros for the port-level checker
`ifndef UNSIGNED_64BIT_ALU_ASSERT_SVH
`define UNSIGNED_64BIT_ALU_ASSERT_SVH
// checked only while out of reset
`define U64_CHK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// checked through reset as well
`define U64_CHK_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`endif

@@ design/u64alu_pkg.sv @@
// types and constants shared by the 64-bit alu
`default_nettype none
package u64alu_pkg;
  localparam logic [3:0] OP_ADD = 4'd0;
  localparam logic [3:0] OP_SUB = 4'd1;
  localparam logic [3:0] OP_MUL = 4'd2;
  localparam logic [3:0] OP_DIV = 4'd3;
  localparam logic [3:0] OP_REM = 4'd4;
  localparam logic [3:0] OP_EQ  = 4'd5;
  localparam logic [3:0] OP_GT  = 4'd6;
  localparam logic [3:0] OP_AND = 4'd7;
  localparam logic [3:0] OP_OR  = 4'd8;
  localparam logic [3:0] OP_XOR = 4'd9;
  localparam logic [3:0] OP_NOT = 4'd10;
  localparam logic [3:0] OP_SHL = 4'd11;
  localparam logic [3:0] OP_SHR = 4'd12;

  localparam int QDEPTH = 4;
  localparam int QAW    = 2;

  typedef struct packed {
    logic [3:0]  action;
    logic [63:0] a_value;
    logic [63:0] b_value;
    logic [7:0]  shift_amount;
  } in_t;

  typedef struct packed {
    logic [63:0] result_value;
    logic        error_flag;
  } out_t;

  typedef enum logic [1:0] {
    CLS_SIMPLE = 2'd0,
    CLS_MUL    = 2'd1,
    CLS_DIV    = 2'd2,
    CLS_DZERO  = 2'd3
  } cls_t;

  typedef struct packed {
    cls_t cls;
    in_t  item;
  } qent_t;
endpackage
`default_nettype wire

@@ design/unsigned_64bit_alu.sv @@
// top level of the 64-bit unsigned alu
`default_nettype none
// A word is taken on every cycle that push is high and full is low, and each
// word gives one result word, in order, after it leaves the internal
// four-word queue and passes through the stage-one and output registers. All
// operations but divide and remainder with a nonzero divisor stream at one
// word per cycle while results are popped; those two run in one shared
// bit-serial divider, one quotient bit per cycle, and hold the back end
// until it is done, while the queue keeps taking words until it fills.
module unsigned_64bit_alu (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_push,
  output logic             in_full,
  input  u64alu_pkg::in_t  in_data,
  output logic             out_empty,
  input  logic             out_pop,
  output u64alu_pkg::out_t out_data
);
  u64alu_pkg::qent_t ent;
  u64alu_pkg::qent_t q_head;
  logic              q_empty;
  logic              q_pop;

  u64alu_front u_front (
    .in_data (in_data),
    .ent     (ent)
  );

  u64alu_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (in_push),
    .wdata (ent),
    .full  (in_full),
    .pop   (q_pop),
    .rdata (q_head),
    .empty (q_empty)
  );

  u64alu_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .out_pop   (out_pop),
    .out_empty (out_empty),
    .out_data  (out_data)
  );
endmodule
`default_nettype wire

@@ design/u64alu_front.sv @@
// front end: sorts each incoming word by the unit that will execute it
`default_nettype none
module u64alu_front (
  input  u64alu_pkg::in_t   in_data,
  output u64alu_pkg::qent_t ent
);
  always_comb begin
    ent.item = in_data;
    unique case (in_data.action) inside
      u64alu_pkg::OP_MUL: begin
        ent.cls = u64alu_pkg::CLS_MUL;
      end
      u64alu_pkg::OP_DIV, u64alu_pkg::OP_REM: begin
        ent.cls = (in_data.b_value == 64'd0) ? u64alu_pkg::CLS_DZERO : u64alu_pkg::CLS_DIV;
      end
      default: begin
        ent.cls = u64alu_pkg::CLS_SIMPLE;
      end
    endcase
  end
endmodule
`default_nettype wire

@@ design/u64alu_queue.sv @@
// short queue between front and back ends
`default_nettype none
module u64alu_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  u64alu_pkg::qent_t wdata,
  output logic              full,
  input  logic              pop,
  output u64alu_pkg::qent_t rdata,
  output logic              empty
);
  u64alu_pkg::qent_t           mem_r [u64alu_pkg::QDEPTH];
  logic [u64alu_pkg::QAW-1:0]  wr_ptr_r;
  logic [u64alu_pkg::QAW-1:0]  rd_ptr_r;
  logic [u64alu_pkg::QAW:0]    cnt_r;
  logic                        do_push;
  logic                        do_pop;

  assign full    = (cnt_r == (u64alu_pkg::QAW+1)'(u64alu_pkg::QDEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end
endmodule
`default_nettype wire

@@ design/u64alu_back.sv @@
// back end: simple ops and split multiply in two stages, iterative divider
`default_nettype none
module u64alu_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_empty,
  input  u64alu_pkg::qent_t q_head,
  output logic              q_pop,
  input  logic              out_pop,
  output logic              out_empty,
  output u64alu_pkg::out_t  out_data
);
  typedef enum logic [2:0] {
    DV_IDLE = 3'b001,
    DV_RUN  = 3'b010,
    DV_DONE = 3'b100
  } dv_state_t;

  logic              out_v_r, out_v_nxt;
  u64alu_pkg::out_t  out_r, out_nxt;
  logic              s1_v_r, s1_v_nxt;
  logic              s1_mul_r, s1_mul_nxt;
  logic [63:0]       s1_val_r, s1_val_nxt;
  logic              s1_err_r, s1_err_nxt;
  logic [63:0]       pp_ll_r, pp_lh_r, pp_hl_r, pp_hh_r;
  logic [63:0]       pp_ll_nxt, pp_lh_nxt, pp_hl_nxt, pp_hh_nxt;
  dv_state_t         dv_state_r, dv_state_nxt;
  logic [63:0]       dv_rem_r, dv_rem_nxt;
  logic [63:0]       dv_quo_r, dv_quo_nxt;
  logic [63:0]       dv_den_r, dv_den_nxt;
  logic [5:0]        dv_cnt_r, dv_cnt_nxt;
  logic              dv_isrem_r, dv_isrem_nxt;

  logic              out_adv;
  logic              s1_take;
  logic [127:0]      prod;
  logic [65:0]       dv_sh;
  logic [65:0]       dv_diff;
  logic              dv_ge;
  logic [64:0]       add_s;
  logic [64:0]       sub_d;
  logic [63:0]       simp_val;
  logic              simp_err;
  u64alu_pkg::in_t   it;

  assign out_adv   = !out_v_r || out_pop;
  assign s1_take   = !s1_v_r || out_adv;
  assign out_empty = !out_v_r;
  assign out_data  = out_r;
  assign it        = q_head.item;

  // full product from the registered partials
  assign prod = {64'd0, pp_ll_r} + {32'd0, pp_lh_r, 32'd0} + {32'd0, pp_hl_r, 32'd0}
              + {pp_hh_r, 64'd0};

  // one restoring step per cycle
  assign dv_sh   = {1'b0, dv_rem_r, dv_quo_r[63]};
  assign dv_diff = dv_sh - {2'b00, dv_den_r};
  assign dv_ge   = !dv_diff[65];

  assign add_s = {1'b0, it.a_value} + {1'b0, it.b_value};
  assign sub_d = {1'b0, it.a_value} - {1'b0, it.b_value};

  always_comb begin
    simp_val = 64'd0;
    simp_err = 1'b0;
    case (it.action)
      u64alu_pkg::OP_ADD: begin
        simp_val = add_s[63:0];
        simp_err = add_s[64];
      end
      u64alu_pkg::OP_SUB: begin
        simp_val = sub_d[63:0];
        simp_err = sub_d[64];
      end
      u64alu_pkg::OP_EQ:  simp_val = {63'd0, it.a_value == it.b_value};
      u64alu_pkg::OP_GT:  simp_val = {63'd0, it.a_value > it.b_value};
      u64alu_pkg::OP_AND: simp_val = it.a_value & it.b_value;
      u64alu_pkg::OP_OR:  simp_val = it.a_value | it.b_value;
      u64alu_pkg::OP_XOR: simp_val = it.a_value ^ it.b_value;
      u64alu_pkg::OP_NOT: simp_val = ~it.a_value;
      u64alu_pkg::OP_SHL: begin
        simp_val = (it.shift_amount < 8'd64) ? (it.a_value << it.shift_amount[5:0]) : 64'd0;
      end
      u64alu_pkg::OP_SHR: begin
        simp_val = (it.shift_amount < 8'd64) ? (it.a_value >> it.shift_amount[5:0]) : 64'd0;
      end
      default: begin
        simp_val = 64'd0;
        simp_err = 1'b0;
      end
    endcase
    if (q_head.cls == u64alu_pkg::CLS_DZERO) begin
      simp_val = 64'd0;
      simp_err = 1'b1;
    end
  end

  always_comb begin
    out_v_nxt    = out_v_r;
    out_nxt      = out_r;
    s1_v_nxt     = s1_v_r;
    s1_mul_nxt   = s1_mul_r;
    s1_val_nxt   = s1_val_r;
    s1_err_nxt   = s1_err_r;
    pp_ll_nxt    = pp_ll_r;
    pp_lh_nxt    = pp_lh_r;
    pp_hl_nxt    = pp_hl_r;
    pp_hh_nxt    = pp_hh_r;
    dv_state_nxt = dv_state_r;
    dv_rem_nxt   = dv_rem_r;
    dv_quo_nxt   = dv_quo_r;
    dv_den_nxt   = dv_den_r;
    dv_cnt_nxt   = dv_cnt_r;
    dv_isrem_nxt = dv_isrem_r;
    q_pop        = 1'b0;

    if (out_adv) begin
      out_v_nxt = s1_v_r;
      if (s1_mul_r) begin
        out_nxt.result_value = prod[63:0];
        out_nxt.error_flag   = |prod[127:64];
      end else begin
        out_nxt.result_value = s1_val_r;
        out_nxt.error_flag   = s1_err_r;
      end
    end

    if (dv_state_r == DV_RUN) begin
      dv_rem_nxt = dv_ge ? dv_diff[63:0] : dv_sh[63:0];
      dv_quo_nxt = {dv_quo_r[62:0], dv_ge};
      dv_cnt_nxt = dv_cnt_r + 6'd1;
      if (dv_cnt_r == 6'd63) begin
        dv_state_nxt = DV_DONE;
      end
    end

    if (s1_take) begin
      s1_v_nxt   = 1'b0;
      s1_mul_nxt = 1'b0;
      unique case (dv_state_r)
        DV_DONE: begin
          s1_v_nxt     = 1'b1;
          s1_val_nxt   = dv_isrem_r ? dv_rem_r : dv_quo_r;
          s1_err_nxt   = 1'b0;
          dv_state_nxt = DV_IDLE;
        end
        DV_IDLE: begin
          if (!q_empty) begin
            q_pop = 1'b1;
            if (q_head.cls == u64alu_pkg::CLS_DIV) begin
              dv_state_nxt = DV_RUN;
              dv_rem_nxt   = 64'd0;
              dv_quo_nxt   = it.a_value;
              dv_den_nxt   = it.b_value;
              dv_cnt_nxt   = 6'd0;
              dv_isrem_nxt = (it.action == u64alu_pkg::OP_REM);
            end else begin
              s1_v_nxt   = 1'b1;
              s1_mul_nxt = (q_head.cls == u64alu_pkg::CLS_MUL);
              s1_val_nxt = simp_val;
              s1_err_nxt = simp_err;
              pp_ll_nxt  = 64'(it.a_value[31:0])  * 64'(it.b_value[31:0]);
              pp_lh_nxt  = 64'(it.a_value[31:0])  * 64'(it.b_value[63:32]);
              pp_hl_nxt  = 64'(it.a_value[63:32]) * 64'(it.b_value[31:0]);
              pp_hh_nxt  = 64'(it.a_value[63:32]) * 64'(it.b_value[63:32]);
            end
          end
        end
        DV_RUN: begin
          s1_v_nxt = 1'b0;
        end
        default: begin
          s1_v_nxt = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    out_r      <= out_nxt;
    s1_mul_r   <= s1_mul_nxt;
    s1_val_r   <= s1_val_nxt;
    s1_err_r   <= s1_err_nxt;
    pp_ll_r    <= pp_ll_nxt;
    pp_lh_r    <= pp_lh_nxt;
    pp_hl_r    <= pp_hl_nxt;
    pp_hh_r    <= pp_hh_nxt;
    dv_rem_r   <= dv_rem_nxt;
    dv_quo_r   <= dv_quo_nxt;
    dv_den_r   <= dv_den_nxt;
    dv_cnt_r   <= dv_cnt_nxt;
    dv_isrem_r <= dv_isrem_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r    <= 1'b0;
      s1_v_r     <= 1'b0;
      dv_state_r <= DV_IDLE;
    end else begin
      out_v_r    <= out_v_nxt;
      s1_v_r     <= s1_v_nxt;
      dv_state_r <= dv_state_nxt;
    end
  end
endmodule
`default_nettype wire

@@ design/u64alu_chk.sv @@
// port-level checker for the 64-bit alu, bound to the top level
`default_nettype none
`include "unsigned_64bit_alu_assert.svh"
module u64alu_chk (
  input logic             clk,
  input logic             rst_n,
  input logic             in_push,
  input logic             in_full,
  input logic             out_empty,
  input logic             out_pop,
  input u64alu_pkg::out_t out_data
);
  // words taken in but not yet popped
  logic [3:0] cnt_r;
  logic       acc_in;
  logic       acc_out;

  assign acc_in  = in_push && !in_full;
  assign acc_out = out_pop && !out_empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (acc_in && !acc_out) begin
      cnt_r <= cnt_r + 4'd1;
    end else if (acc_out && !acc_in) begin
      cnt_r <= cnt_r - 4'd1;
    end
  end

  `U64_CHK(a_no_extra_result, (cnt_r == 4'd0) |-> out_empty, "result with nothing outstanding")
  `U64_CHK(a_full_has_backlog, in_full |-> (cnt_r >= 4'd4), "full with short backlog")
  `U64_CHK(a_result_held, (!out_empty && !out_pop) |=> (!out_empty && $stable(out_data)), "result changed while waiting")
  `U64_CHK_RST(a_reset_empty, !rst_n |=> out_empty, "result present after reset")
endmodule

bind unsigned_64bit_alu u64alu_chk u_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_push   (in_push),
  .in_full   (in_full),
  .out_empty (out_empty),
  .out_pop   (out_pop),
  .out_data  (out_data)
);
`default_nettype wire
